// File: rtl/core/cpp_pkg.sv
// types and constants shared by the closest-pair block
// no dependencies; cpp_dist, closest_pair_of_points, cpp_checker and tb_top import this package
`default_nettype none

package cpp_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = 2 * COORD_W + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } coord_pair_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
  } point_t;

  typedef struct packed {
    logic [DIST_W-1:0] min_dist_sq;
    coord_t            first_x;
    coord_t            first_y;
    coord_t            second_x;
    coord_t            second_y;
    logic              pair_found;
    logic              capacity_overflow;
  } result_t;

  typedef struct packed {
    logic busy;
    logic out_valid;
  } dist_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_STORE,
    ST_EMIT
  } cpp_state_t;

endpackage

`default_nettype wire

// File: rtl/core/cpp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module cpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/cpp_dist.sv
// pipelined squared-distance unit: difference stage, square stage, sum out
// depends on cpp_pkg
`default_nettype none

module cpp_dist (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  cpp_pkg::coord_pair_t      stored,
  input  cpp_pkg::coord_pair_t      probe,
  output cpp_pkg::dist_status_t     status,
  output logic [cpp_pkg::DIST_W-1:0] dist_sq,
  output cpp_pkg::coord_pair_t      out_stored
);
  import cpp_pkg::*;

  logic                     v1;
  logic                     v2;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  coord_pair_t              s1_pt;
  logic [SQ_W-1:0]          sqx;
  logic [SQ_W-1:0]          sqy;
  coord_pair_t              s2_pt;
  logic signed [2*DIFF_W-1:0] prod_x;
  logic signed [2*DIFF_W-1:0] prod_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // sign-extend one bit so the difference never wraps
  always_ff @(posedge clk) begin
    dx    <= {stored.x[COORD_W-1], stored.x} - {probe.x[COORD_W-1], probe.x};
    dy    <= {stored.y[COORD_W-1], stored.y} - {probe.y[COORD_W-1], probe.y};
    s1_pt <= stored;
  end

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  // squares are never negative and fit in SQ_W bits
  always_ff @(posedge clk) begin
    sqx   <= prod_x[SQ_W-1:0];
    sqy   <= prod_y[SQ_W-1:0];
    s2_pt <= s1_pt;
  end

  assign dist_sq          = {1'b0, sqx} + {1'b0, sqy};
  assign out_stored       = s2_pt;
  assign status.out_valid = v2;
  assign status.busy      = v1 | v2;

endmodule

`default_nettype wire

// File: rtl/core/closest_pair_of_points.sv
// closest pair of 2d points: each point is scanned against the stored set with back-to-back
// ram reads, one per stored point; the single ram read port paces the scan; a last point
// then loads the result; point_stall stays high from an accepted point until it is stored
// (or dropped when full) and any result it closes is loaded, so points are taken one at a time
// reset (sync, active high) clears state, count, best distance/pair, overflow, result valid
`default_nettype none

module closest_pair_of_points #(
  parameter int MAX_POINTS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              point_valid,
  output logic              point_stall,
  input  cpp_pkg::point_t   point,
  output logic              result_valid,
  input  logic              result_stall,
  output cpp_pkg::result_t  result
);
  import cpp_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_POINTS);

  cpp_state_t        state;
  cpp_state_t        state_next;
  point_t            pt;
  logic [CW-1:0]     count;
  logic [AW-1:0]     idx;
  logic              issue_q;
  logic [DIST_W-1:0] best_dist;
  coord_pair_t       best_first;
  coord_pair_t       best_second;
  logic              overflow;

  logic              accept;
  logic              issue;
  logic              ram_we;
  logic              load_result;
  logic              full;
  logic              scan_end;
  logic              improve;
  coord_pair_t       probe;
  coord_pair_t       rdata;
  coord_pair_t       cand;
  logic [DIST_W-1:0] dist_sq;
  dist_status_t      dstat;
  logic              found;

  assign accept   = point_valid & ~point_stall;
  assign full     = (count == COUNT_FULL);
  assign scan_end = (CW'(idx) == count - CW'(1));
  assign probe    = '{x: pt.point_x, y: pt.point_y};
  assign improve  = dstat.out_valid & (dist_sq < best_dist);
  assign found    = (count >= CW'(2));

  cpp_ram #(
    .WIDTH ($bits(coord_pair_t)),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (probe),
    .raddr (idx),
    .rdata (rdata)
  );

  cpp_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (issue_q),
    .stored     (rdata),
    .probe      (probe),
    .status     (dstat),
    .dist_sq    (dist_sq),
    .out_stored (cand)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            state_next = point.last_point ? ST_EMIT : ST_IDLE;
          end else if (count == '0) begin
            state_next = ST_STORE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!issue_q && !dstat.busy) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        state_next = pt.last_point ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    point_stall = 1'b1;
    issue       = 1'b0;
    ram_we      = 1'b0;
    load_result = 1'b0;
    unique case (state)
      ST_IDLE:  point_stall = 1'b0;
      ST_SCAN:  issue       = 1'b1;
      ST_DRAIN: ;
      ST_STORE: ram_we      = 1'b1;
      ST_EMIT:  load_result = ~result_valid | ~result_stall;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      idx          <= '0;
      issue_q      <= 1'b0;
      best_dist    <= DIST_MAX;
      best_first   <= '0;
      best_second  <= '0;
      overflow     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state   <= state_next;
      issue_q <= issue;

      if (accept) begin
        idx <= '0;
        if (full) begin
          overflow <= 1'b1;
        end
      end else if (issue) begin
        idx <= idx + AW'(1);
      end

      // pipeline delivers candidates in store order, so strict less keeps the first tie
      if (improve) begin
        best_dist   <= dist_sq;
        best_first  <= cand;
        best_second <= probe;
      end

      if (ram_we) begin
        count <= count + CW'(1);
      end

      if (load_result) begin
        count       <= '0;
        best_dist   <= DIST_MAX;
        best_first  <= '0;
        best_second <= '0;
        overflow    <= 1'b0;
      end

      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pt <= point;
    end
    if (load_result) begin
      result.min_dist_sq       <= found ? best_dist : DIST_MAX;
      result.first_x           <= found ? best_first.x : '0;
      result.first_y           <= found ? best_first.y : '0;
      result.second_x          <= found ? best_second.x : '0;
      result.second_y          <= found ? best_second.y : '0;
      result.pair_found        <= found;
      result.capacity_overflow <= overflow;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cpp_checker.sv
// port-level checks for the closest-pair block, bound to the top level
// depends on cpp_pkg and closest_pair_of_points
`default_nettype none

module cpp_checker (
  input logic              clk,
  input logic              rst,
  input logic              point_valid,
  input logic              point_stall,
  input cpp_pkg::point_t   point,
  input logic              result_valid,
  input logic              result_stall,
  input cpp_pkg::result_t  result
);
  import cpp_pkg::*;

  localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(2) * DIST_W'({SQ_W{1'b1}} >> COORD_W)
                                             * DIST_W'({SQ_W{1'b1}} >> COORD_W) + DIST_W'(1)
                                             - DIST_W'(1);

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // without a pair the word carries the empty-set values
  a_empty_set: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.pair_found |->
      result.min_dist_sq == DIST_MAX && result.first_x == '0 && result.first_y == '0 &&
      result.second_x == '0 && result.second_y == '0)
    else $error("empty result carries stale pair");

  // a real pair never reports the empty marker or more than the largest distance
  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pair_found |-> result.min_dist_sq <= DIST_LIMIT)
    else $error("pair distance out of range");

  // a result never rises in the cycle after a point is accepted
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_stall |=> !$rose(result_valid))
    else $error("result appeared in the cycle after a point");

endmodule

bind closest_pair_of_points cpp_checker u_cpp_checker (.*);

`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench for closest_pair_of_points: random and directed point sets
// depends on cpp_pkg and closest_pair_of_points in rtl/core; expected results are computed here
`timescale 1ns / 1ps

module tb_top;
  import cpp_pkg::*;

  localparam int MAX_POINTS   = 256;
  localparam int TARGET_ITEMS = 1750;
  localparam int HOLD_CYCLES  = 1500;
  localparam int CYCLE_LIMIT  = 2_500_000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    point_valid = 1'b0;
  logic    point_stall;
  point_t  point = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  closest_pair_of_points #(.MAX_POINTS(MAX_POINTS)) dut (
    .clk(clk),
    .rst(rst),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point(point),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  point_t  pending_points[$];
  result_t expected_results[$];
  int      total_points;
  int      accepted_points;
  int      results_checked;
  int      mismatches;
  int      hold_left;
  int      cycle_count;

  // running closest-pair state of the set being received
  coord_t            kept_x[MAX_POINTS];
  coord_t            kept_y[MAX_POINTS];
  int                kept_count = 0;
  longint            closest_sq = longint'(DIST_MAX);
  coord_t            near_x1 = '0, near_y1 = '0, near_x2 = '0, near_y2 = '0;
  bit                dropped_seen = 1'b0;

  function automatic longint sq_dist(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  task automatic absorb_point(point_t p);
    longint  d;
    result_t r;
    bit      found;
    if (kept_count < MAX_POINTS) begin
      for (int i = 0; i < kept_count; i++) begin
        d = sq_dist(kept_x[i], kept_y[i], p.point_x, p.point_y);
        if (d < closest_sq) begin
          closest_sq = d;
          near_x1 = kept_x[i];
          near_y1 = kept_y[i];
          near_x2 = p.point_x;
          near_y2 = p.point_y;
        end
      end
      kept_x[kept_count] = p.point_x;
      kept_y[kept_count] = p.point_y;
      kept_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (p.last_point) begin
      found = kept_count >= 2;
      r.min_dist_sq       = found ? closest_sq[DIST_W-1:0] : DIST_MAX;
      r.first_x           = found ? near_x1 : '0;
      r.first_y           = found ? near_y1 : '0;
      r.second_x          = found ? near_x2 : '0;
      r.second_y          = found ? near_y2 : '0;
      r.pair_found        = found;
      r.capacity_overflow = dropped_seen;
      expected_results.push_back(r);
      kept_count   = 0;
      closest_sq   = longint'(DIST_MAX);
      near_x1      = '0;
      near_y1      = '0;
      near_x2      = '0;
      near_y2      = '0;
      dropped_seen = 1'b0;
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result word with nothing expected: %p", got);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (got.min_dist_sq !== want.min_dist_sq) begin
      $error("min_dist_sq: expected %0d, got %0d", want.min_dist_sq, got.min_dist_sq);
      mismatches++;
    end
    if (got.first_x !== want.first_x) begin
      $error("first_x: expected %0d, got %0d", want.first_x, got.first_x);
      mismatches++;
    end
    if (got.first_y !== want.first_y) begin
      $error("first_y: expected %0d, got %0d", want.first_y, got.first_y);
      mismatches++;
    end
    if (got.second_x !== want.second_x) begin
      $error("second_x: expected %0d, got %0d", want.second_x, got.second_x);
      mismatches++;
    end
    if (got.second_y !== want.second_y) begin
      $error("second_y: expected %0d, got %0d", want.second_y, got.second_y);
      mismatches++;
    end
    if (got.pair_found !== want.pair_found) begin
      $error("pair_found: expected %0d, got %0d", want.pair_found, got.pair_found);
      mismatches++;
    end
    if (got.capacity_overflow !== want.capacity_overflow) begin
      $error("capacity_overflow: expected %0d, got %0d",
             want.capacity_overflow, got.capacity_overflow);
      mismatches++;
    end
  endtask

  // idle percentage per side: sender 25 / receiver 48, then swapped, then none
  function automatic int idle_pct(bit receiver);
    int phase;
    phase = (total_points > 0) ? accepted_points * 3 / total_points : 0;
    case (phase)
      0: return receiver ? 48 : 25;
      1: return receiver ? 25 : 48;
      default: return 0;
    endcase
  endfunction

  task automatic add_point(int x, int y, bit last);
    point_t p;
    p.point_x    = x[COORD_W-1:0];
    p.point_y    = y[COORD_W-1:0];
    p.last_point = last;
    pending_points.push_back(p);
  endtask

  function automatic int edge_coord();
    case ($urandom_range(4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // style 0: full range, 1: tight cluster (ties, duplicates), 2: extreme values
  task automatic make_random_set(int n);
    int style, cx, cy, spread, x, y;
    style  = $urandom_range(2);
    cx     = int'($urandom_range(65535)) - 32768;
    cy     = int'($urandom_range(65535)) - 32768;
    spread = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: begin
          x = int'($urandom_range(65535)) - 32768;
          y = int'($urandom_range(65535)) - 32768;
        end
        1: begin
          x = cx + int'($urandom_range(2 * spread)) - spread;
          y = cy + int'($urandom_range(2 * spread)) - spread;
        end
        default: begin
          x = edge_coord();
          y = edge_coord();
        end
      endcase
      add_point(x, y, i == n - 1);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else begin
      if (point_valid && !point_stall) begin
        absorb_point(pending_points.pop_front());
        accepted_points++;
      end
      if (!point_valid || !point_stall) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          point_valid <= 1'b1;
          point       <= pending_points[0];
        end else begin
          point_valid <= 1'b0;
        end
      end
    end
  end

  // monitor, with two long hold-offs so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result(result);
        results_checked++;
        if (results_checked == 25 || results_checked == 100)
          hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= $urandom_range(99) < idle_pct(1'b1);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    bit full_set_done, over_set_done;
    full_set_done = 1'b0;
    over_set_done = 1'b0;

    // single point: no pair
    add_point(-32768, 32767, 1'b1);
    // opposite corners: largest distance
    add_point(-32768, -32768, 1'b0);
    add_point(32767, 32767, 1'b1);
    // equal distances: the pair found first stays
    add_point(0, 0, 1'b0);
    add_point(10, 0, 1'b0);
    add_point(0, 10, 1'b1);
    // duplicate point: zero distance, earlier one first
    add_point(-1, -1, 1'b0);
    add_point(7, -3, 1'b0);
    add_point(-1, -1, 1'b1);
    // later comparison beats earlier one
    add_point(0, 0, 1'b0);
    add_point(32767, -32768, 1'b0);
    add_point(-32768, 32767, 1'b0);
    add_point(32766, -32768, 1'b1);
    // two single-point sets back to back
    add_point(32767, -1, 1'b1);
    add_point(0, -32768, 1'b1);

    while (pending_points.size() < TARGET_ITEMS) begin
      if (!full_set_done && pending_points.size() >= 600) begin
        make_random_set(MAX_POINTS);
        full_set_done = 1'b1;
      end else if (!over_set_done && pending_points.size() >= 1200) begin
        // store overflows and the point marked last is itself dropped
        make_random_set(MAX_POINTS + 3);
        over_set_done = 1'b1;
      end else if ($urandom_range(9) == 0) begin
        make_random_set(1);
      end else if ($urandom_range(5) == 0) begin
        make_random_set($urandom_range(17, 40));
      end else begin
        make_random_set($urandom_range(2, 16));
      end
    end
    total_points = pending_points.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_points.size() > 0 || point_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (MAX_POINTS + 16) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: closest_pair_of_points.f
rtl/core/cpp_pkg.sv
rtl/core/cpp_ram.sv
rtl/core/cpp_dist.sv
rtl/core/closest_pair_of_points.sv
rtl/core/cpp_checker.sv
sim/tb_top.sv
